>>> sv/hsvcd_pkg.sv
`timescale 1ns / 1ps
// Shared constants and helpers for the HSV drift / HSV-to-RGB block.
// No dependencies.
package hsvcd_pkg;

    localparam int SHAPES = 8;
    localparam int IDX_W  = 3;

    // what an input beat asks for (carried on tuser)
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // fixed point: 32768 = 1.0, hue in degrees * 128
    localparam logic signed [17:0] S_FULL   = 18'sd32768;
    localparam logic signed [17:0] S_HALF   = 18'sd16384;
    localparam logic signed [17:0] S_VLOW   = 18'sd13107;
    localparam logic signed [17:0] S_ZERO   = 18'sd0;
    localparam logic signed [17:0] HUE_TURN = 18'sd46080;
    localparam logic [16:0]        U_FULL   = 17'd32768;
    localparam logic [15:0]        V_FULL   = 16'd32768;
    localparam int                 SECTOR   = 7680;

    // x / 7680 = (x >> 9) / 15, and y / 15 = (y * RECIP) >> RECIP_SH for y < 2^19
    localparam int              SECT_SH  = 9;
    localparam logic [19:0]     RECIP    = 20'd559241;
    localparam int              RECIP_SH = 23;

    localparam logic signed [10:0] RATE_MIN = -11'sd1024;
    localparam logic signed [10:0] RATE_MAX = 11'sd1023;

    // negate a rate, saturating the one case that has no positive twin
    function automatic logic signed [10:0] flip_rate(input logic signed [10:0] r);
        flip_rate = (r == RATE_MIN) ? RATE_MAX : -r;
    endfunction

endpackage

>>> sv/hsv_color_drift_to_rgb.sv
`timescale 1ns / 1ps
// HSV color drift per entry with six-sector HSV to RGB conversion.
// Depends on hsvcd_pkg.
//
// Load beat: written in the accept cycle, next beat taken the following cycle.
// Step beat: states ST_UPD, ST_SECT, ST_SF1, ST_SF2, ST_QQ, ST_TT, ST_FIN (grey: ST_UPD,
//   ST_FIN); the result is registered in ST_FIN and s_tready is back high at that edge,
//   after any wait for the previous result to leave the output register.
//   One 20x20 multiplier is reused for p, s*rem, the divide by 15, q and t.
// aresetn (sync, active low) clears all color entries, the sequencer and m_tvalid.
module hsv_color_drift_to_rgb (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // shape_index[2:0], hue_in[18:3], sat_in[34:19], val_in[50:35],
    // hue_rate_in[59:51], sat_rate_in[70:60], val_rate_in[81:71], zero pad
    input  logic [87:0] s_tdata,
    // func
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // shape_out[2:0], red[18:3], green[34:19], blue[50:35], zero pad
    output logic [55:0] m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_UPD, ST_SECT, ST_SF1, ST_SF2, ST_QQ, ST_TT, ST_FIN
    } state_t;

    state_t state_reg;

    // color entries
    logic        [15:0] hue_mem_reg  [hsvcd_pkg::SHAPES];
    logic signed [17:0] sat_mem_reg  [hsvcd_pkg::SHAPES];
    logic        [15:0] val_mem_reg  [hsvcd_pkg::SHAPES];
    logic signed [8:0]  hrate_mem_reg[hsvcd_pkg::SHAPES];
    logic signed [10:0] srate_mem_reg[hsvcd_pkg::SHAPES];
    logic signed [10:0] vrate_mem_reg[hsvcd_pkg::SHAPES];

    // working registers
    logic [hsvcd_pkg::IDX_W-1:0] idx_reg;
    logic        grey_reg;
    logic [15:0] h_reg;
    logic [15:0] su_reg;
    logic [15:0] v_reg;
    logic [2:0]  sec_reg;
    logic [12:0] rem_reg;
    logic [15:0] sf_reg;
    logic [15:0] p_reg;
    logic [15:0] q_reg;
    logic [39:0] prod_reg;

    logic        m_tvalid_reg;
    logic [55:0] m_tdata_reg;

    // input beat fields
    logic [hsvcd_pkg::IDX_W-1:0] in_idx;
    logic        in_valid_idx;
    logic        in_accept;

    assign in_idx       = s_tdata[2:0];
    assign in_valid_idx = ({1'b0, in_idx} < 4'(hsvcd_pkg::SHAPES));
    assign s_tready     = (state_reg == ST_IDLE);
    assign in_accept    = s_tvalid && s_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;

    // ---- update stage: rate reversal, add, clamp, wrap ----
    logic        [15:0] h_cur;
    logic signed [17:0] s_cur;
    logic signed [17:0] v_cur;
    logic signed [8:0]  hr_cur;
    logic signed [10:0] sr_cur;
    logic signed [10:0] vr_cur;
    logic signed [10:0] sr_new;
    logic signed [10:0] vr_new;
    logic signed [17:0] s_sum;
    logic signed [17:0] v_sum;
    logic signed [17:0] h_sum;
    logic        [15:0] h_wrap;
    logic        [15:0] v_clamp;
    logic signed [17:0] s_clamp;
    logic               grey;

    always_comb begin
        h_cur  = hue_mem_reg[idx_reg];
        s_cur  = sat_mem_reg[idx_reg];
        v_cur  = $signed({2'b00, val_mem_reg[idx_reg]});
        hr_cur = hrate_mem_reg[idx_reg];
        sr_cur = srate_mem_reg[idx_reg];
        vr_cur = vrate_mem_reg[idx_reg];

        sr_new = sr_cur;
        if ((s_cur <= hsvcd_pkg::S_HALF && sr_cur < 0) ||
            (s_cur >= hsvcd_pkg::S_FULL && sr_cur > 0)) begin
            sr_new = hsvcd_pkg::flip_rate(sr_cur);
        end
        vr_new = vr_cur;
        if ((v_cur <= hsvcd_pkg::S_VLOW && vr_cur < 0) ||
            (v_cur >= hsvcd_pkg::S_FULL && vr_cur > 0)) begin
            vr_new = hsvcd_pkg::flip_rate(vr_cur);
        end

        s_sum = s_cur + {{7{sr_new[10]}}, sr_new};
        v_sum = v_cur + {{7{vr_new[10]}}, vr_new};
        h_sum = $signed({2'b00, h_cur}) + {{9{hr_cur[8]}}, hr_cur};

        if (h_sum < 0) begin
            h_wrap = 16'(h_sum + hsvcd_pkg::HUE_TURN);
        end else if (h_sum >= hsvcd_pkg::HUE_TURN) begin
            h_wrap = 16'(h_sum - hsvcd_pkg::HUE_TURN);
        end else begin
            h_wrap = h_sum[15:0];
        end

        if (v_sum < 0) begin
            v_clamp = 16'd0;
        end else if (v_sum > hsvcd_pkg::S_FULL) begin
            v_clamp = hsvcd_pkg::V_FULL;
        end else begin
            v_clamp = v_sum[15:0];
        end

        grey    = (s_sum <= hsvcd_pkg::S_ZERO);
        s_clamp = (s_sum > hsvcd_pkg::S_FULL) ? hsvcd_pkg::S_FULL : s_sum;
    end

    // ---- sector split of the wrapped hue ----
    logic [2:0]  sec_now;
    logic [15:0] sec_base;

    always_comb begin
        if (h_reg >= 16'(5 * hsvcd_pkg::SECTOR)) begin
            sec_now = 3'd5; sec_base = 16'(5 * hsvcd_pkg::SECTOR);
        end else if (h_reg >= 16'(4 * hsvcd_pkg::SECTOR)) begin
            sec_now = 3'd4; sec_base = 16'(4 * hsvcd_pkg::SECTOR);
        end else if (h_reg >= 16'(3 * hsvcd_pkg::SECTOR)) begin
            sec_now = 3'd3; sec_base = 16'(3 * hsvcd_pkg::SECTOR);
        end else if (h_reg >= 16'(2 * hsvcd_pkg::SECTOR)) begin
            sec_now = 3'd2; sec_base = 16'(2 * hsvcd_pkg::SECTOR);
        end else if (h_reg >= 16'(hsvcd_pkg::SECTOR)) begin
            sec_now = 3'd1; sec_base = 16'(hsvcd_pkg::SECTOR);
        end else begin
            sec_now = 3'd0; sec_base = 16'd0;
        end
    end

    // ---- shared multiplier operand select ----
    logic [19:0] mul_a;
    logic [19:0] mul_b;
    logic [15:0] sf_now;
    logic [16:0] k_p;
    logic [16:0] k_q;
    logic [16:0] k_t;
    logic [15:0] t_now;

    assign sf_now = prod_reg[hsvcd_pkg::RECIP_SH +: 16];
    assign k_p    = hsvcd_pkg::U_FULL - {1'b0, su_reg};
    assign k_q    = hsvcd_pkg::U_FULL - {1'b0, sf_now};
    assign k_t    = hsvcd_pkg::U_FULL - {1'b0, su_reg} + {1'b0, sf_reg};
    assign t_now  = prod_reg[30:15];

    always_comb begin
        case (state_reg)
            ST_SECT: begin
                mul_a = {4'd0, v_reg};
                mul_b = {3'd0, k_p};
            end
            ST_SF1: begin
                mul_a = {4'd0, su_reg};
                mul_b = {7'd0, rem_reg};
            end
            ST_SF2: begin
                mul_a = {1'b0, prod_reg[hsvcd_pkg::SECT_SH +: 19]};
                mul_b = hsvcd_pkg::RECIP;
            end
            ST_QQ: begin
                mul_a = {4'd0, v_reg};
                mul_b = {3'd0, k_q};
            end
            ST_TT, ST_FIN: begin
                mul_a = {4'd0, v_reg};
                mul_b = {3'd0, k_t};
            end
            default: begin
                mul_a = 20'd0;
                mul_b = 20'd0;
            end
        endcase
    end

    // ---- six-sector output select ----
    logic [15:0] r_sel;
    logic [15:0] g_sel;
    logic [15:0] b_sel;

    always_comb begin
        if (grey_reg) begin
            r_sel = v_reg; g_sel = v_reg; b_sel = v_reg;
        end else begin
            case (sec_reg)
                3'd0:    begin r_sel = v_reg; g_sel = t_now; b_sel = p_reg; end
                3'd1:    begin r_sel = q_reg; g_sel = v_reg; b_sel = p_reg; end
                3'd2:    begin r_sel = p_reg; g_sel = v_reg; b_sel = t_now; end
                3'd3:    begin r_sel = p_reg; g_sel = q_reg; b_sel = v_reg; end
                3'd4:    begin r_sel = t_now; g_sel = p_reg; b_sel = v_reg; end
                default: begin r_sel = v_reg; g_sel = p_reg; b_sel = q_reg; end
            endcase
        end
    end

    // ---- sequencer, stores and output register ----
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;

        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < hsvcd_pkg::SHAPES; i++) begin
                hue_mem_reg[i]   <= '0;
                sat_mem_reg[i]   <= '0;
                val_mem_reg[i]   <= '0;
                hrate_mem_reg[i] <= '0;
                srate_mem_reg[i] <= '0;
                vrate_mem_reg[i] <= '0;
            end
        end else begin
            // ST_FIN either reloads the output register or is waiting with m_tready low
            if (m_tready && state_reg != ST_FIN) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept && in_valid_idx) begin
                        idx_reg <= in_idx;
                        if (s_tuser == hsvcd_pkg::FUNC_LOAD) begin
                            hue_mem_reg[in_idx]   <= s_tdata[18:3];
                            sat_mem_reg[in_idx]   <= $signed({2'b00, s_tdata[34:19]});
                            val_mem_reg[in_idx]   <= s_tdata[50:35];
                            hrate_mem_reg[in_idx] <= $signed(s_tdata[59:51]);
                            srate_mem_reg[in_idx] <= $signed(s_tdata[70:60]);
                            vrate_mem_reg[in_idx] <= $signed(s_tdata[81:71]);
                        end else begin
                            state_reg <= ST_UPD;
                        end
                    end
                end
                ST_UPD: begin
                    srate_mem_reg[idx_reg] <= sr_new;
                    vrate_mem_reg[idx_reg] <= vr_new;
                    hue_mem_reg[idx_reg]   <= h_wrap;
                    val_mem_reg[idx_reg]   <= v_clamp;
                    sat_mem_reg[idx_reg]   <= grey ? s_sum : s_clamp;
                    h_reg    <= h_wrap;
                    v_reg    <= v_clamp;
                    su_reg   <= s_clamp[15:0];
                    grey_reg <= grey;
                    state_reg <= grey ? ST_FIN : ST_SECT;
                end
                ST_SECT: begin
                    sec_reg   <= sec_now;
                    rem_reg   <= 13'(h_reg - sec_base);
                    state_reg <= ST_SF1;
                end
                ST_SF1: begin
                    p_reg     <= prod_reg[30:15];
                    state_reg <= ST_SF2;
                end
                ST_SF2: begin
                    state_reg <= ST_QQ;
                end
                ST_QQ: begin
                    sf_reg    <= sf_now;
                    state_reg <= ST_TT;
                end
                ST_TT: begin
                    q_reg     <= prod_reg[30:15];
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    // hold here until the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {5'd0, b_sel, g_sel, r_sel, idx_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> dv/hsv_color_drift_to_rgb_test.sv
`timescale 1ns / 1ps
// Self-checking bench for hsv_color_drift_to_rgb: a short directed table, then random
// load/step traffic; every color beat is checked against a table value or an in-bench predictor.
// Depends on hsvcd_pkg and the block RTL.
module hsv_color_drift_to_rgb_test;

    localparam int FULL_SCALE   = 32768;
    localparam int HALF_SCALE   = 16384;
    localparam int VAL_FLOOR    = 13107;
    localparam int HUE_WRAP     = 46080;
    localparam int RANDOM_ITEMS = 1550;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic               func;
        logic [2:0]         idx;
        logic [15:0]        hue;
        logic [15:0]        sat;
        logic [15:0]        val;
        logic signed [8:0]  hrate;
        logic signed [10:0] srate;
        logic signed [10:0] vrate;
    } color_beat_t;

    typedef struct {
        logic [2:0]  idx;
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
    } color_t;

    typedef struct {
        color_beat_t beat;
        bit          typed;
        color_t      want;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    always #5 aclk = ~aclk;

    hsv_color_drift_to_rgb dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // per-entry color and drift, mirrored from what has been accepted
    logic [16:0]        ent_hue   [hsvcd_pkg::SHAPES];
    logic [16:0]        ent_sat   [hsvcd_pkg::SHAPES];
    logic [16:0]        ent_val   [hsvcd_pkg::SHAPES];
    logic signed [8:0]  ent_hrate [hsvcd_pkg::SHAPES];
    logic signed [10:0] ent_srate [hsvcd_pkg::SHAPES];
    logic signed [10:0] ent_vrate [hsvcd_pkg::SHAPES];

    color_t    colors_due[$];
    stim_row_t stim_rows[$];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int loads_sent    = 0;
    int steps_sent    = 0;
    int colors_seen   = 0;
    int mismatches    = 0;

    function automatic logic [87:0] pack_beat(input color_beat_t b);
        return {6'b0, b.vrate, b.srate, b.hrate, b.val, b.sat, b.hue, b.idx};
    endfunction

    // negation saturates at the 11-bit rate range
    function automatic int reverse_rate(input int r);
        return (r <= -1024) ? 1023 : -r;
    endfunction

    function automatic void load_entry(input color_beat_t b);
        ent_hue[b.idx]   = {1'b0, b.hue};
        ent_sat[b.idx]   = {1'b0, b.sat};
        ent_val[b.idx]   = {1'b0, b.val};
        ent_hrate[b.idx] = b.hrate;
        ent_srate[b.idx] = b.srate;
        ent_vrate[b.idx] = b.vrate;
    endfunction

    function automatic color_t step_entry(input logic [2:0] i);
        int h, s, v, sr, vr, rem, sf, p, q, t;
        color_t c;
        s  = int'(ent_sat[i]);
        v  = int'(ent_val[i]);
        sr = int'(ent_srate[i]);
        vr = int'(ent_vrate[i]);
        if (s <= HALF_SCALE && sr < 0) sr = reverse_rate(sr);
        if (s >= FULL_SCALE && sr > 0) sr = reverse_rate(sr);
        if (v <= VAL_FLOOR && vr < 0) vr = reverse_rate(vr);
        if (v >= FULL_SCALE && vr > 0) vr = reverse_rate(vr);
        ent_srate[i] = 11'(sr);
        ent_vrate[i] = 11'(vr);

        h = (int'(ent_hue[i]) + int'(ent_hrate[i])) % HUE_WRAP;
        if (h < 0) h += HUE_WRAP;
        s += sr;
        v += vr;
        if (v < 0) v = 0;
        if (v > FULL_SCALE) v = FULL_SCALE;
        ent_hue[i] = 17'(h);
        ent_val[i] = 17'(v);
        c.idx = i;

        if (s <= 0) begin
            // grey: saturation kept as is
            ent_sat[i] = 17'(s);
            c.r = 16'(v);
            c.g = 16'(v);
            c.b = 16'(v);
        end else begin
            if (s > FULL_SCALE) s = FULL_SCALE;
            ent_sat[i] = 17'(s);
            rem = h % hsvcd_pkg::SECTOR;
            sf  = (s * rem) / hsvcd_pkg::SECTOR;
            p   = (v * (FULL_SCALE - s)) >> 15;
            q   = (v * (FULL_SCALE - sf)) >> 15;
            t   = (v * (FULL_SCALE - s + sf)) >> 15;
            case (h / hsvcd_pkg::SECTOR)
                0: begin
                    c.r = 16'(v); c.g = 16'(t); c.b = 16'(p);
                end
                1: begin
                    c.r = 16'(q); c.g = 16'(v); c.b = 16'(p);
                end
                2: begin
                    c.r = 16'(p); c.g = 16'(v); c.b = 16'(t);
                end
                3: begin
                    c.r = 16'(p); c.g = 16'(q); c.b = 16'(v);
                end
                4: begin
                    c.r = 16'(t); c.g = 16'(p); c.b = 16'(v);
                end
                default: begin
                    c.r = 16'(v); c.g = 16'(p); c.b = 16'(q);
                end
            endcase
        end
        return c;
    endfunction

    function automatic void add_row(input logic func, input int idx, input int hue,
                                    input int sat, input int val, input int hrate,
                                    input int srate, input int vrate, input bit typed,
                                    input int r, input int g, input int b);
        stim_row_t row;
        row.beat.func  = func;
        row.beat.idx   = 3'(idx);
        row.beat.hue   = 16'(hue);
        row.beat.sat   = 16'(sat);
        row.beat.val   = 16'(val);
        row.beat.hrate = 9'(hrate);
        row.beat.srate = 11'(srate);
        row.beat.vrate = 11'(vrate);
        row.typed      = typed;
        row.want.idx   = 3'(idx);
        row.want.r     = 16'(r);
        row.want.g     = 16'(g);
        row.want.b     = 16'(b);
        stim_rows.push_back(row);
    endfunction

    function automatic color_beat_t rand_beat();
        color_beat_t b;
        int pick;
        b.func  = ($urandom_range(99) < 22) ? hsvcd_pkg::FUNC_LOAD : hsvcd_pkg::FUNC_STEP;
        b.idx   = 3'($urandom_range(hsvcd_pkg::SHAPES - 1));
        // raw bits everywhere; steps ignore them, loads mostly override below
        b.hue   = 16'($urandom());
        b.sat   = 16'($urandom());
        b.val   = 16'($urandom());
        b.hrate = 9'($urandom());
        b.srate = 11'($urandom());
        b.vrate = 11'($urandom());
        if (b.func == hsvcd_pkg::FUNC_LOAD) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                b.hue = 16'($urandom_range(HUE_WRAP - 1));
                b.sat = 16'($urandom_range(FULL_SCALE));
                b.val = 16'($urandom_range(FULL_SCALE));
            end else if (pick < 92) begin
                // sit on the bounce points and sector edges
                b.hue = 16'(hsvcd_pkg::SECTOR * $urandom_range(5) + $urandom_range(2));
                b.sat = $urandom_range(1) ? 16'(HALF_SCALE - 2 + $urandom_range(4))
                                          : 16'(FULL_SCALE - 2 + $urandom_range(4));
                b.val = $urandom_range(1) ? 16'(VAL_FLOOR - 2 + $urandom_range(4))
                                          : 16'(FULL_SCALE - 2 + $urandom_range(4));
            end
            if ($urandom_range(5) == 0)
                b.srate = $urandom_range(1) ? 11'sd1023 : -11'sd1024;
            if ($urandom_range(5) == 0)
                b.vrate = $urandom_range(1) ? 11'sd1023 : -11'sd1024;
        end
        return b;
    endfunction

    task automatic send_beat(input color_beat_t b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_beat(b);
        s_tuser  <= b.func;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic run_beat(input color_beat_t b, input bit typed, input color_t want);
        color_t c;
        send_beat(b);
        if (b.func == hsvcd_pkg::FUNC_LOAD) begin
            load_entry(b);
            loads_sent++;
        end else begin
            c = step_entry(b.idx);
            if (typed) begin
                c.r = want.r;
                c.g = want.g;
                c.b = want.b;
            end
            colors_due.push_back(c);
            steps_sent++;
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        color_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.idx = m_tdata[2:0];
            got.r   = m_tdata[18:3];
            got.g   = m_tdata[34:19];
            got.b   = m_tdata[50:35];
            colors_seen++;
            if (colors_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected color beat: entry %0d rgb %0d %0d %0d",
                             $realtime, got.idx, got.r, got.g, got.b);
            end else begin
                want = colors_due.pop_front();
                if (got.idx != want.idx || got.r != want.r || got.g != want.g ||
                    got.b != want.b) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: mismatch: want %0d rgb %0d %0d %0d, got %0d rgb %0d %0d %0d",
                                 $realtime, want.idx, want.r, want.g, want.b,
                                 got.idx, got.r, got.g, got.b);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        color_t none;
        none = '{default: '0};
        for (int k = 0; k < hsvcd_pkg::SHAPES; k++) begin
            ent_hue[k]   = '0;
            ent_sat[k]   = '0;
            ent_val[k]   = '0;
            ent_hrate[k] = '0;
            ent_srate[k] = '0;
            ent_vrate[k] = '0;
        end

        // untouched entries step to black; a step ignores its payload
        add_row(hsvcd_pkg::FUNC_STEP, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(hsvcd_pkg::FUNC_STEP, 7, 65535, 65535, 65535, -1, -1, -1, 1, 0, 0, 0);
        // sector starts at full saturation and value
        add_row(hsvcd_pkg::FUNC_LOAD, 1, 0, FULL_SCALE, FULL_SCALE, 0, 0, 0, 0, 0, 0, 0);
        add_row(hsvcd_pkg::FUNC_STEP, 1, 0, 0, 0, 0, 0, 0, 1, FULL_SCALE, 0, 0);
        add_row(hsvcd_pkg::FUNC_LOAD, 2, hsvcd_pkg::SECTOR, FULL_SCALE, FULL_SCALE,
                0, 0, 0, 0, 0, 0, 0);
        add_row(hsvcd_pkg::FUNC_STEP, 2, 0, 0, 0, 0, 0, 0, 1, FULL_SCALE, FULL_SCALE, 0);
        add_row(hsvcd_pkg::FUNC_LOAD, 3, 2 * hsvcd_pkg::SECTOR, FULL_SCALE, FULL_SCALE,
                0, 0, 0, 0, 0, 0, 0);
        add_row(hsvcd_pkg::FUNC_STEP, 3, 0, 0, 0, 0, 0, 0, 1, 0, FULL_SCALE, 0);
        add_row(hsvcd_pkg::FUNC_LOAD, 4, 3 * hsvcd_pkg::SECTOR, FULL_SCALE, FULL_SCALE,
                0, 0, 0, 0, 0, 0, 0);
        add_row(hsvcd_pkg::FUNC_STEP, 4, 0, 0, 0, 0, 0, 0, 1, 0, FULL_SCALE, FULL_SCALE);
        add_row(hsvcd_pkg::FUNC_LOAD, 5, 4 * hsvcd_pkg::SECTOR, FULL_SCALE, FULL_SCALE,
                0, 0, 0, 0, 0, 0, 0);
        add_row(hsvcd_pkg::FUNC_STEP, 5, 0, 0, 0, 0, 0, 0, 1, 0, 0, FULL_SCALE);
        add_row(hsvcd_pkg::FUNC_LOAD, 6, 5 * hsvcd_pkg::SECTOR, FULL_SCALE, FULL_SCALE,
                0, 0, 0, 0, 0, 0, 0);
        add_row(hsvcd_pkg::FUNC_STEP, 6, 0, 0, 0, 0, 0, 0, 1, FULL_SCALE, 0, FULL_SCALE);
        // grey at full value
        add_row(hsvcd_pkg::FUNC_LOAD, 7, 12345, 0, FULL_SCALE, 0, 0, 0, 0, 0, 0, 0);
        add_row(hsvcd_pkg::FUNC_STEP, 7, 0, 0, 0, 0, 0, 0, 1,
                FULL_SCALE, FULL_SCALE, FULL_SCALE);
        // hue wraps below zero, -1024 rates reverse to +1023 at the low bounds
        add_row(hsvcd_pkg::FUNC_LOAD, 0, 0, HALF_SCALE, VAL_FLOOR, -256, -1024, -1024,
                0, 0, 0, 0);
        add_row(hsvcd_pkg::FUNC_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(hsvcd_pkg::FUNC_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // hue wraps past 360, rates reverse at the top bounds
        add_row(hsvcd_pkg::FUNC_LOAD, 1, HUE_WRAP - 1, FULL_SCALE, FULL_SCALE, 255, 1023,
                1023, 0, 0, 0, 0);
        add_row(hsvcd_pkg::FUNC_STEP, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // out-of-range load, clamped (hue wrapped) on the step
        add_row(hsvcd_pkg::FUNC_LOAD, 2, 65535, 65535, 65535, -256, 1023, -1024,
                0, 0, 0, 0);
        add_row(hsvcd_pkg::FUNC_STEP, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // saturation pushed over full scale
        add_row(hsvcd_pkg::FUNC_LOAD, 3, 20000, 32000, 20000, 100, 1023, -1024,
                0, 0, 0, 0);
        add_row(hsvcd_pkg::FUNC_STEP, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct  = 21;
        sink_idle_pct = 66;
        foreach (stim_rows[k])
            run_beat(stim_rows[k].beat, stim_rows[k].typed, stim_rows[k].want);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                src_idle_pct  = 66;
                sink_idle_pct = 21;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            run_beat(rand_beat(), 1'b0, none);
        end
        s_tvalid <= 1'b0;

        while (colors_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d loads and %0d steps under three idle patterns.",
                 loads_sent, steps_sent);
        $display("Checked %0d color beats, %0d mismatches.", colors_seen, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
